FILE: rtl/tcpfs_pkg.sv
// Package: shared types, constants and status codes of the two-class scheduler.
`timescale 1ns / 1ps
package tcpfs_pkg;
    localparam int URGENT_DEPTH  = 16;
    localparam int REGULAR_DEPTH = 16;
    localparam int UW = $clog2(URGENT_DEPTH);
    localparam int RW = $clog2(REGULAR_DEPTH);
    localparam logic [7:0]  THRESH_RESET = 8'd5;
    localparam logic [31:0] ID_RESET     = 32'd1;

    typedef enum logic [2:0] {
        ST_Q_URGENT  = 3'd0,
        ST_Q_REGULAR = 3'd1,
        ST_S_URGENT  = 3'd2,
        ST_S_REGULAR = 3'd3,
        ST_NONE      = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        logic        action;
        logic [7:0]  priority_req;
        logic [31:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] item_id;
        logic [31:0] item_tag;
        logic [7:0]  item_priority;
    } t_out_item;

    // Classified command passed from front to back.
    typedef struct packed {
        logic        serve;
        logic        urgent;
        logic [7:0]  prio;
        logic [31:0] tag;
    } t_cmd;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] tag;
        logic [7:0]  prio;
    } t_entry;
endpackage

FILE: rtl/tcpfs_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tcpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/tcpfs_front.sv
// Front end: accept items, classify against the threshold, two-entry command queue.
`timescale 1ns / 1ps
module tcpfs_front import tcpfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  t_in_item   i_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_take
);
    logic [7:0] r_thresh;
    t_cmd       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    assign o_full      = (r_cnt == 2'd2);
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        w_cmd.serve  = i_item.action;
        w_cmd.urgent = (i_item.priority_req > r_thresh);
        w_cmd.prio   = i_item.priority_req;
        w_cmd.tag    = i_item.tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_rd     <= 1'b0;
            r_wr     <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_take);
        end
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end
endmodule

FILE: rtl/tcpfs_back.sv
// Back end: sorted urgent shift store, regular FIFO in RAM, result register.
`timescale 1ns / 1ps
module tcpfs_back import tcpfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_empty,
    output t_out_item o_item,
    input  logic      i_pop
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_OUT} t_state;

    t_state       r_state;
    t_entry       r_u [URGENT_DEPTH];
    logic [UW:0]  r_ucnt;
    logic [RW-1:0] r_head;
    logic [RW:0]  r_rcnt;
    logic [31:0]  r_next_id;
    t_out_item    r_out;
    logic         w_ufull, w_rfull, w_we;
    logic [RW-1:0] w_waddr;
    t_entry       w_rd, w_new;

    assign w_ufull   = (r_ucnt == (UW+1)'(URGENT_DEPTH));
    assign w_rfull   = (r_rcnt == (RW+1)'(REGULAR_DEPTH));
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign o_empty   = (r_state != S_OUT);
    assign o_item    = r_out;
    assign w_waddr   = r_head + r_rcnt[RW-1:0];
    assign w_new     = '{id: r_next_id, tag: i_cmd.tag, prio: i_cmd.prio};
    assign w_we      = o_cmd_take && !i_cmd.serve && !i_cmd.urgent && !w_rfull;

    tcpfs_ram #(.WIDTH($bits(t_entry)), .DEPTH(REGULAR_DEPTH)) u_reg_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_new),
        .i_raddr(r_head),
        .o_rdata(w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ucnt    <= '0;
            r_head    <= '0;
            r_rcnt    <= '0;
            r_next_id <= ID_RESET;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_state <= S_OUT;
                        if (!i_cmd.serve) begin
                            if (i_cmd.urgent ? w_ufull : w_rfull) begin
                                r_out <= '{ST_FULL, 32'd0, i_cmd.tag, i_cmd.prio};
                            end else begin
                                r_out <= '{i_cmd.urgent ? ST_Q_URGENT : ST_Q_REGULAR,
                                           r_next_id, i_cmd.tag, i_cmd.prio};
                                r_next_id <= r_next_id + 32'd1;
                                if (i_cmd.urgent) begin
                                    // insert after all entries of priority >= new
                                    for (int k = URGENT_DEPTH-1; k >= 0; k--) begin
                                        if ((UW+1)'(k) < r_ucnt &&
                                            r_u[k].prio >= i_cmd.prio) begin
                                            r_u[k] <= r_u[k];
                                        end else if (k > 0 && (UW+1)'(k-1) < r_ucnt &&
                                                     r_u[k-1].prio < i_cmd.prio) begin
                                            r_u[k] <= r_u[k-1];
                                        end else if ((UW+1)'(k) <= r_ucnt) begin
                                            r_u[k] <= w_new;
                                        end
                                    end
                                    r_ucnt <= r_ucnt + 1'b1;
                                end else begin
                                    r_rcnt <= r_rcnt + 1'b1;
                                end
                            end
                        end else if (r_ucnt != '0) begin
                            r_out <= '{ST_S_URGENT, r_u[0].id, r_u[0].tag, r_u[0].prio};
                            for (int k = 0; k < URGENT_DEPTH-1; k++) begin
                                r_u[k] <= r_u[k+1];
                            end
                            r_ucnt <= r_ucnt - 1'b1;
                        end else if (r_rcnt != '0) begin
                            // wait in S_READ for the registered RAM read at the head
                            r_state <= S_READ;
                        end else begin
                            r_out <= '{ST_NONE, 32'd0, 32'd0, 8'd0};
                        end
                    end
                end
                S_READ: begin
                    r_out   <= '{ST_S_REGULAR, w_rd.id, w_rd.tag, w_rd.prio};
                    r_head  <= r_head + 1'b1;
                    r_rcnt  <= r_rcnt - 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/two_class_priority_fifo_scheduler_top.sv
// Top level of the two-class priority scheduler.
`timescale 1ns / 1ps
// Items enter through a push/full queue port; each either registers a new entry
// (action 0) or serves the next waiting one (action 1). Entries of priority strictly
// above the threshold register go to a 16-entry sorted shift store (highest priority
// first, ties in arrival order); others go to a 16-entry FIFO held in RAM. A serve
// takes the urgent head if any, else the FIFO head. Each item gives one result on
// the empty/pop port. The front end classifies and buffers up to two items, so the
// input stays open while a result waits. The back end handles one item at a time:
// it takes no new item until the result of the last one is popped, and a regular
// serve passes through an extra read state, as the FIFO RAM read is registered.
// Write the threshold only while the block is idle.
module two_class_priority_fifo_scheduler_top import tcpfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in_item,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_out_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);
    t_cmd w_cmd;
    logic w_cmd_valid, w_cmd_take;

    // Classify and queue incoming items.
    tcpfs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_in_item), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    // Carry out each command against the two stores.
    tcpfs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_take(w_cmd_take), .o_empty(empty), .o_item(o_out_item), .i_pop(pop)
    );
endmodule

FILE: test/tb_top.sv
// Testbench for the two-class priority scheduler: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import tcpfs_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    t_in_item   i_in_item;
    logic       empty;
    logic       pop;
    t_out_item  o_out_item;
    logic       i_cfg_we;
    logic [7:0] i_cfg_data;

    two_class_priority_fifo_scheduler_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: threshold, id counter, sorted urgent store and regular FIFO.
    logic [7:0]  thresh;
    logic [31:0] next_id;
    t_entry      urg_q[$];
    t_entry      reg_q[$];
    t_out_item   sched_expected[$];

    int fails = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_urgent = 0;
    int n_full = 0;
    int idle_cycles = 0;
    bit stall_enable = 1;
    localparam int WATCHDOG = 5000;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the one result that an item causes and advance the model.
    function automatic t_out_item schedule_item(t_in_item it);
        t_out_item r;
        t_entry    e;
        int        pos;
        r = '0;
        if (!it.action) begin
            r.item_tag = it.tag;
            r.item_priority = it.priority_req;
            e.id = next_id;
            e.tag = it.tag;
            e.prio = it.priority_req;
            if (it.priority_req > thresh) begin
                if (urg_q.size() >= URGENT_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < urg_q.size() && urg_q[pos].prio >= e.prio) pos++;
                    urg_q.insert(pos, e);
                    r.status = ST_Q_URGENT;
                    r.item_id = next_id;
                    next_id++;
                end
            end else begin
                if (reg_q.size() >= REGULAR_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    reg_q.push_back(e);
                    r.status = ST_Q_REGULAR;
                    r.item_id = next_id;
                    next_id++;
                end
            end
        end else if (urg_q.size() > 0) begin
            e = urg_q.pop_front();
            r = {ST_S_URGENT, e.id, e.tag, e.prio};
        end else if (reg_q.size() > 0) begin
            e = reg_q.pop_front();
            r = {ST_S_REGULAR, e.id, e.tag, e.prio};
        end else begin
            r.status = ST_NONE;
        end
        return r;
    endfunction

    // Send one item: hold it until accepted, then predict.
    task automatic send_item(input logic act, input logic [7:0] pr, input logic [31:0] tg);
        t_in_item it;
        it.action = act;
        it.priority_req = pr;
        it.tag = tg;
        i_in_item = it;
        push = 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sched_expected.push_back(schedule_item(it));
        n_sent++;
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // Send an item and, in random mode, leave a random gap at the end of a burst.
    int burst_left = 0;
    task automatic send_burst(input logic act, input logic [7:0] pr, input logic [31:0] tg);
        send_item(act, pr, tg);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic drain;
        while (sched_expected.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_threshold(input logic [7:0] v);
        drain();
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thresh = v;
    endtask

    // Result checker: compare each popped result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && pop && !empty) begin
            idle_cycles <= 0;
            if (sched_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         o_out_item);
                fails++;
            end else begin
                exp_r = sched_expected.pop_front();
                n_checked++;
                if (o_out_item.status != exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, o_out_item.status);
                    fails++;
                end
                if (o_out_item.item_id != exp_r.item_id) begin
                    $display("%0t: item_id expected %h actual %h", $time,
                             exp_r.item_id, o_out_item.item_id);
                    fails++;
                end
                if (o_out_item.item_tag != exp_r.item_tag) begin
                    $display("%0t: item_tag expected %h actual %h", $time,
                             exp_r.item_tag, o_out_item.item_tag);
                    fails++;
                end
                if (o_out_item.item_priority != exp_r.item_priority) begin
                    $display("%0t: item_priority expected %h actual %h", $time,
                             exp_r.item_priority, o_out_item.item_priority);
                    fails++;
                end
            end
        end else if (push && !full) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stalls at random unless stalling is off: pop is high with 65 percent chance.
    always @(negedge i_clk) begin
        if (!stall_enable) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(0, 99) < 65);
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("%0t: watchdog expired", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_empty_and_extremes;
        send_item(1'b1, 8'hFF, 32'hFFFFFFFF);   // nothing waiting, fields ignored
        send_item(1'b0, 8'd5, 32'h0);           // at threshold: regular
        send_item(1'b0, 8'd6, 32'hFFFFFFFF);    // just above: urgent
        send_item(1'b0, 8'hFF, 32'hA5A5A5A5);
        send_item(1'b0, 8'h00, 32'h5A5A5A5A);
        send_item(1'b0, 8'd6, 32'h12345678);    // tie with earlier 6
        repeat (6) send_item(1'b1, 8'($urandom), $urandom);
    endtask

    task automatic test_store_full;
        for (int i = 0; i < URGENT_DEPTH + 2; i++) send_item(1'b0, 8'd200, 32'(i));
        for (int i = 0; i < REGULAR_DEPTH + 2; i++) send_item(1'b0, 8'd1, 32'(i));
        repeat (URGENT_DEPTH + REGULAR_DEPTH + 1) send_item(1'b1, 8'd0, 32'd0);
    endtask

    // Mostly registrations with biased priorities, serves in between.
    task automatic test_random(input int n);
        logic [7:0] pr;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: pr = 8'($urandom);
                1: pr = 8'(32'(thresh) + $urandom_range(0, 2) - 32'd1);
                default: pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            if (pr > thresh) n_urgent++;
            send_burst($urandom_range(0, 99) < 45, pr, $urandom);
        end
    endtask

    initial begin
        push = 0;
        pop = 0;
        i_in_item = '0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_rst_n = 0;
        thresh = THRESH_RESET;
        next_id = ID_RESET;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        test_empty_and_extremes();
        test_store_full();
        set_threshold(8'd0);
        test_random(100);
        // Pause until the block has caught up completely.
        drain();
        stall_enable = 0;
        test_random(50);
        stall_enable = 1;
        set_threshold(8'hFF);
        test_random(80);
        set_threshold(8'd128);
        test_random(60);
        set_threshold(8'd5);
        test_random(30);
        drain();

        $display("Sent %0d items, checked %0d results; thresholds 0, 255, 128 and 5.",
                 n_sent, n_checked);
        $display("Covered both store-full cases, empty serves and priority ties.");
        if (fails == 0 && sched_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/tcpfs_pkg.sv
rtl/tcpfs_ram.sv
rtl/tcpfs_front.sv
rtl/tcpfs_back.sv
rtl/two_class_priority_fifo_scheduler_top.sv
test/tb_top.sv
